@@ hw/rtl/pwbs_pkg.sv @@
// ----------------------------------------------------------------------------
// pwbs_pkg
// Shared constants, codes and types of the particle wind/bounce step block.
// ----------------------------------------------------------------------------
package pwbs_pkg;

	// fixed-point format and sizing
	localparam int FRAC_BITS     = 20;
	localparam int MAX_PARTICLES = 1024;
	localparam int FIELD_W       = 24;
	localparam int LIM_W         = 23;
	localparam int COLOR_W       = 21;
	localparam int HEAT_TOT_W    = 31;
	localparam int HEAT_W        = FRAC_BITS + 1;
	localparam int SQ_ACC_W      = 2 * FIELD_W - 1;
	localparam int SQ_W          = 2 * FIELD_W - FRAC_BITS;
	localparam int MUL_W         = 30;
	localparam int PROD_W        = 2 * MUL_W;

	localparam longint ONE_Q   = longint'(1) <<< FRAC_BITS;
	localparam longint TICK_Q  = (ONE_Q + 60) / 120;
	localparam longint TENTH_Q = (ONE_Q + 5) / 10;
	localparam longint RAMP_K  = ONE_Q - TENTH_Q;
	localparam longint ACC31_MAX    = 64'sd2147483647;
	localparam longint HEAT_CAP_RAW = longint'(MAX_PARTICLES) <<< FRAC_BITS;
	localparam longint HEAT_CAP     = (HEAT_CAP_RAW < ACC31_MAX) ? HEAT_CAP_RAW : ACC31_MAX;

	// register reset values
	localparam logic signed [FIELD_W-1:0] RST_BOUND_LO = FIELD_W'(-ONE_Q);
	localparam logic signed [FIELD_W-1:0] RST_BOUND_HI = FIELD_W'(ONE_Q);
	localparam logic signed [FIELD_W-1:0] RST_ACC_X    = FIELD_W'((ONE_Q * 2 + 5) / 10);
	localparam logic signed [FIELD_W-1:0] RST_ACC_Y    = FIELD_W'(-((ONE_Q * 33 + 50) / 100));
	localparam logic [LIM_W-1:0]          RST_LIMIT    = LIM_W'((ONE_Q * 11 + 5) / 10);
	localparam logic [LIM_W-1:0]          RST_SCALE    = LIM_W'((ONE_Q * 25) / 64);

	// stream layout
	localparam int S_TDATA_W    = 4 * FIELD_W;
	localparam int OUT_RED_LSB  = 4 * FIELD_W;
	localparam int OUT_BLUE_LSB = OUT_RED_LSB + COLOR_W;
	localparam int OUT_HEAT_LSB = OUT_BLUE_LSB + COLOR_W;
	localparam int OUT_USED_W   = OUT_HEAT_LSB + HEAT_TOT_W;
	localparam int M_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = FIELD_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOUND_LEFT   = 3'd0,
		REG_BOUND_RIGHT  = 3'd1,
		REG_BOUND_BOTTOM = 3'd2,
		REG_BOUND_TOP    = 3'd3,
		REG_ACC_X_START  = 3'd4,
		REG_ACC_Y_START  = 3'd5,
		REG_SPEED_LIMIT  = 3'd6,
		REG_HEAT_SCALE   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WCLAMP,
		ST_M_WAX,
		ST_M_WAY,
		ST_M_WVX,
		ST_M_WVY,
		ST_M_SQX,
		ST_M_NVX,
		ST_M_SQY,
		ST_M_NVY,
		ST_M_HEAT,
		ST_HEAT,
		ST_M_RAMP,
		ST_FIN
	} ctl_state_t;

	// multiplier operand pair
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_WAX,
		MUL_WAY,
		MUL_WVX,
		MUL_WVY,
		MUL_SQX,
		MUL_SQY,
		MUL_NVX,
		MUL_NVY,
		MUL_HEAT,
		MUL_RAMP
	} mul_sel_t;

	// consumer of the registered product
	typedef enum logic [3:0] {
		USE_NONE,
		USE_WVX,
		USE_WVY,
		USE_NVX,
		USE_NVY,
		USE_SQ0,
		USE_SQ1,
		USE_POSX,
		USE_POSY,
		USE_HEAT,
		USE_ACC
	} use_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     wind_clamp;
		mul_sel_t mul_sel;
		use_sel_t use_sel;
		logic     load_out;
	} ctl_cmd_t;

endpackage

@@ hw/rtl/pwbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pwbs_ctrl
// Sequencer: walks one item through the shared multiplier schedule and
// owns the input/output handshakes.
// ----------------------------------------------------------------------------
module pwbs_ctrl import pwbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	input  logic     s_axis_tuser,
	output logic     s_axis_tready,
	output logic     m_axis_tvalid,
	input  logic     m_axis_tready,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       first_q;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				first_q <= s_axis_tuser;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// each ST_M_* state issues one multiply; a state mostly consumes the product of the multiply before it
	always_comb begin
		state_d        = state_q;
		s_axis_tready  = 1'b0;
		cmd.load_in    = 1'b0;
		cmd.wind_clamp = 1'b0;
		cmd.mul_sel    = MUL_NONE;
		cmd.use_sel    = USE_NONE;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load_in   = s_axis_tvalid;
				if (s_axis_tvalid) begin
					state_d = s_axis_tuser ? ST_WCLAMP : ST_M_WVX;
				end
			end
			ST_WCLAMP: begin
				cmd.wind_clamp = 1'b1;
				state_d        = ST_M_WAX;
			end
			ST_M_WAX: begin
				cmd.mul_sel = MUL_WAX;
				state_d     = ST_M_WAY;
			end
			ST_M_WAY: begin
				cmd.mul_sel = MUL_WAY;
				cmd.use_sel = USE_WVX;
				state_d     = ST_M_WVX;
			end
			ST_M_WVX: begin
				cmd.mul_sel = MUL_WVX;
				cmd.use_sel = first_q ? USE_WVY : USE_NONE;
				state_d     = ST_M_WVY;
			end
			ST_M_WVY: begin
				cmd.mul_sel = MUL_WVY;
				cmd.use_sel = USE_NVX;
				state_d     = ST_M_SQX;
			end
			ST_M_SQX: begin
				cmd.mul_sel = MUL_SQX;
				cmd.use_sel = USE_NVY;
				state_d     = ST_M_NVX;
			end
			ST_M_NVX: begin
				cmd.mul_sel = MUL_NVX;
				cmd.use_sel = USE_SQ0;
				state_d     = ST_M_SQY;
			end
			ST_M_SQY: begin
				cmd.mul_sel = MUL_SQY;
				cmd.use_sel = USE_POSX;
				state_d     = ST_M_NVY;
			end
			ST_M_NVY: begin
				cmd.mul_sel = MUL_NVY;
				cmd.use_sel = USE_SQ1;
				state_d     = ST_M_HEAT;
			end
			ST_M_HEAT: begin
				cmd.mul_sel = MUL_HEAT;
				cmd.use_sel = USE_POSY;
				state_d     = ST_HEAT;
			end
			ST_HEAT: begin
				cmd.use_sel = USE_HEAT;
				state_d     = ST_M_RAMP;
			end
			ST_M_RAMP: begin
				cmd.mul_sel = MUL_RAMP;
				cmd.use_sel = USE_ACC;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// product holds until the output register frees up
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/pwbs_dp.sv @@
// ----------------------------------------------------------------------------
// pwbs_dp
// Datapath: config registers, wind state, heat sum, one shared signed
// multiplier with a registered product, and the result register.
// ----------------------------------------------------------------------------
module pwbs_dp import pwbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [S_TDATA_W-1:0]  in_tdata,
	input  logic                  in_tlast,
	output logic [M_TDATA_W-1:0]  out_tdata,
	output logic                  out_tlast
);

	localparam int SUM_W = FIELD_W + 2;

	localparam logic signed [SUM_W-1:0]  S24_MAX   = SUM_W'((longint'(1) <<< (FIELD_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0]  S24_MIN   = SUM_W'(-(longint'(1) <<< (FIELD_W - 1)));
	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(ONE_Q / 2);
	localparam logic signed [MUL_W-1:0]  TICK_OP   = MUL_W'(TICK_Q);
	localparam logic signed [MUL_W-1:0]  RAMP_OP   = MUL_W'(RAMP_K);
	localparam logic [SQ_ACC_W:0]        SQ_HALF   = (SQ_ACC_W + 1)'(ONE_Q / 2);
	localparam logic [HEAT_W-1:0]        HEAT_ONE  = HEAT_W'(ONE_Q);
	localparam logic [HEAT_TOT_W:0]      CAP_Q     = (HEAT_TOT_W + 1)'(HEAT_CAP);
	localparam logic [COLOR_W-1:0]       COLOR_ONE = COLOR_W'(ONE_Q);
	localparam logic [COLOR_W-1:0]       COLOR_TEN = COLOR_W'(TENTH_Q);

	function automatic logic signed [FIELD_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
		logic signed [FIELD_W-1:0] r;
		if (v > S24_MAX) begin
			r = S24_MAX[FIELD_W-1:0];
		end else if (v < S24_MIN) begin
			r = S24_MIN[FIELD_W-1:0];
		end else begin
			r = v[FIELD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [FIELD_W-1:0] neg_sat(input logic signed [FIELD_W-1:0] v);
		logic signed [SUM_W-1:0] w;
		w = -{{2{v[FIELD_W-1]}}, v};
		return sat24(w);
	endfunction

	function automatic logic signed [SUM_W-1:0] sx(input logic signed [FIELD_W-1:0] v);
		return {{2{v[FIELD_W-1]}}, v};
	endfunction

	function automatic logic signed [MUL_W-1:0] op24(input logic signed [FIELD_W-1:0] v);
		return {{(MUL_W - FIELD_W){v[FIELD_W-1]}}, v};
	endfunction

	// config
	logic signed [FIELD_W-1:0] bound_left_q, bound_right_q, bound_bottom_q, bound_top_q;
	logic [LIM_W-1:0]          limit_q, scale_q;

	// tick state
	logic signed [FIELD_W-1:0] wvx_q, wvy_q, wax_q, way_q;
	logic [HEAT_TOT_W-1:0]     acc_q;

	// per-item working registers
	logic signed [FIELD_W-1:0] px_q, py_q, vx_q, vy_q;
	logic signed [FIELD_W-1:0] nvx_q, nvy_q, npx_q, npy_q;
	logic                      last_q;
	logic [SQ_ACC_W-1:0]       sq_acc_q;
	logic [SQ_W-1:0]           sq_q;
	logic [HEAT_W-1:0]         heat_q;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [MUL_W-1:0]   op_a, op_b;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [SUM_W-1:0]   tt;
	logic signed [SUM_W-1:0]   lim_p, lim_n;
	logic signed [SUM_W-1:0]   pos_sum;
	logic signed [SUM_W-1:0]   pos_lo, pos_hi;
	logic signed [FIELD_W-1:0] pos_src, vel_src;
	logic [SQ_ACC_W:0]         sq_sum;
	logic [HEAT_TOT_W:0]       acc_sum;
	logic [COLOR_W-1:0]        ramp;
	logic [HEAT_TOT_W-1:0]     heat_out;

	// product rounded to nearest, ties up: floor((p + half) / 2^F)
	assign prod_rnd = (prod_q + PROD_HALF) >>> FRAC_BITS;
	assign tt       = prod_rnd[SUM_W-1:0];
	assign lim_p    = SUM_W'(limit_q);
	assign lim_n    = -lim_p;
	assign sq_sum   = {1'b0, sq_acc_q} + (SQ_ACC_W + 1)'(prod_q[SQ_ACC_W-1:0]) + SQ_HALF;
	assign acc_sum  = {1'b0, acc_q} + (HEAT_TOT_W + 1)'(heat_q);
	assign ramp     = prod_rnd[COLOR_W-1:0];
	assign heat_out = last_q ? acc_q : '0;

	// shared position step for either axis
	always_comb begin
		if (cmd.use_sel == USE_POSY) begin
			pos_src = py_q;
			vel_src = nvy_q;
			pos_lo  = sx(bound_bottom_q);
			pos_hi  = sx(bound_top_q);
		end else begin
			pos_src = px_q;
			vel_src = nvx_q;
			pos_lo  = sx(bound_left_q);
			pos_hi  = sx(bound_right_q);
		end
		pos_sum = sx(pos_src) + tt;
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_WAX: begin
				op_a = op24(wax_q);
				op_b = TICK_OP;
			end
			MUL_WAY: begin
				op_a = op24(way_q);
				op_b = TICK_OP;
			end
			MUL_WVX: begin
				op_a = op24(wvx_q);
				op_b = TICK_OP;
			end
			MUL_WVY: begin
				op_a = op24(wvy_q);
				op_b = TICK_OP;
			end
			MUL_SQX: begin
				op_a = op24(vx_q);
				op_b = op24(vx_q);
			end
			MUL_SQY: begin
				op_a = op24(vy_q);
				op_b = op24(vy_q);
			end
			MUL_NVX: begin
				op_a = op24(nvx_q);
				op_b = TICK_OP;
			end
			MUL_NVY: begin
				op_a = op24(nvy_q);
				op_b = TICK_OP;
			end
			MUL_HEAT: begin
				op_a = MUL_W'(sq_q);
				op_b = MUL_W'(scale_q);
			end
			MUL_RAMP: begin
				op_a = MUL_W'(heat_q);
				op_b = RAMP_OP;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// config, wind state and heat sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_left_q   <= RST_BOUND_LO;
			bound_right_q  <= RST_BOUND_HI;
			bound_bottom_q <= RST_BOUND_LO;
			bound_top_q    <= RST_BOUND_HI;
			limit_q        <= RST_LIMIT;
			scale_q        <= RST_SCALE;
			wvx_q          <= '0;
			wvy_q          <= '0;
			wax_q          <= RST_ACC_X;
			way_q          <= RST_ACC_Y;
			acc_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_BOUND_LEFT:   bound_left_q   <= cfg_data;
					REG_BOUND_RIGHT:  bound_right_q  <= cfg_data;
					REG_BOUND_BOTTOM: bound_bottom_q <= cfg_data;
					REG_BOUND_TOP:    bound_top_q    <= cfg_data;
					REG_ACC_X_START:  wax_q          <= cfg_data;
					REG_ACC_Y_START:  way_q          <= cfg_data;
					REG_SPEED_LIMIT:  limit_q        <= cfg_data[LIM_W-1:0];
					REG_HEAT_SCALE:   scale_q        <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.wind_clamp) begin
				// out-of-limit wind: clamp velocity, reverse acceleration
				if (sx(wvx_q) > lim_p) begin
					wvx_q <= lim_p[FIELD_W-1:0];
					wax_q <= neg_sat(wax_q);
				end else if (sx(wvx_q) < lim_n) begin
					wvx_q <= lim_n[FIELD_W-1:0];
					wax_q <= neg_sat(wax_q);
				end
				if (sx(wvy_q) > lim_p) begin
					wvy_q <= lim_p[FIELD_W-1:0];
					way_q <= neg_sat(way_q);
				end else if (sx(wvy_q) < lim_n) begin
					wvy_q <= lim_n[FIELD_W-1:0];
					way_q <= neg_sat(way_q);
				end
				acc_q <= '0;
			end
			if (cmd.use_sel == USE_WVX) begin
				wvx_q <= sat24(sx(wvx_q) + tt);
			end
			if (cmd.use_sel == USE_WVY) begin
				wvy_q <= sat24(sx(wvy_q) + tt);
			end
			if (cmd.use_sel == USE_ACC) begin
				acc_q <= (acc_sum > CAP_Q) ? CAP_Q[HEAT_TOT_W-1:0] : acc_sum[HEAT_TOT_W-1:0];
			end
		end
	end

	// per-item datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q   <= in_tdata[0*FIELD_W +: FIELD_W];
			py_q   <= in_tdata[1*FIELD_W +: FIELD_W];
			vx_q   <= in_tdata[2*FIELD_W +: FIELD_W];
			vy_q   <= in_tdata[3*FIELD_W +: FIELD_W];
			last_q <= in_tlast;
		end
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= op_a * op_b;
		end
		case (cmd.use_sel)
			USE_NVX: nvx_q    <= sat24(sx(vx_q) + tt);
			USE_NVY: nvy_q    <= sat24(sx(vy_q) + tt);
			USE_SQ0: sq_acc_q <= prod_q[SQ_ACC_W-1:0];
			USE_SQ1: sq_q     <= sq_sum[FRAC_BITS +: SQ_W];
			USE_HEAT: begin
				heat_q <= (prod_rnd > PROD_W'(HEAT_ONE)) ? HEAT_ONE : prod_rnd[HEAT_W-1:0];
			end
			USE_POSX, USE_POSY: begin
				logic signed [FIELD_W-1:0] p_new, v_new;
				p_new = pos_sum[FIELD_W-1:0];
				v_new = vel_src;
				if (pos_sum < pos_lo) begin
					p_new = pos_lo[FIELD_W-1:0];
					v_new = neg_sat(vel_src);
				end else if (pos_sum > pos_hi) begin
					p_new = pos_hi[FIELD_W-1:0];
					v_new = neg_sat(vel_src);
				end
				if (cmd.use_sel == USE_POSY) begin
					npy_q <= p_new;
					nvy_q <= v_new;
				end else begin
					npx_q <= p_new;
					nvx_q <= v_new;
				end
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_tdata <= {(M_TDATA_W - OUT_USED_W)'(0), heat_out, COLOR_ONE - ramp,
				COLOR_TEN + ramp, nvy_q, nvx_q, npy_q, npx_q};
			out_tlast <= last_q;
		end
	end

endmodule

@@ hw/rtl/particle_wind_bounce_step_top.sv @@
// ----------------------------------------------------------------------------
// particle_wind_bounce_step_top
// One Euler step per particle with shared wind, wall bounce, heat and color.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one particle per item; tuser marks the first particle of a
//   tick (wind update, heat sum cleared), tlast the last one. m_axis returns
//   one item per particle; its tlast repeats the input tlast and only then
//   is heat_total nonzero.
//   cfg_* writes register cfg_index (0..7) with cfg_data; write only while
//   the block is idle. Writing an acceleration start register also reloads
//   the live wind acceleration.
//   The single shared 30x30 multiplier performs the eight to ten products of
//   an item in sequence, so the block takes a new item only after the last
//   one has reached its last step; the first item of a tick adds a wind
//   clamp step and two more products.
//   The result sits in an output register; the next item is taken while it
//   waits. If m_axis stalls, the following item finishes its math and then
//   holds in its last step until the output register frees up.
//   Reset (arst_n low) clears the wind velocity and heat sum, reloads the
//   config registers and the wind acceleration with their defaults, and
//   drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module particle_wind_bounce_step_top import pwbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
	input  logic                  s_axis_tuser,  // first_of_tick
	input  logic                  s_axis_tlast,  // last_of_tick
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, color_red, color_blue,
	// heat_total, zero pad
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	output logic                  m_axis_tlast,  // tick_done
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	pwbs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd)
	);

	pwbs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tdata  (s_axis_tdata),
		.in_tlast  (s_axis_tlast),
		.out_tdata (m_axis_tdata),
		.out_tlast (m_axis_tlast)
	);

endmodule

@@ hw/rtl/pwbs_checker.sv @@
// ----------------------------------------------------------------------------
// pwbs_checker
// Port-level checks of the particle step block, bound to the top level.
// ----------------------------------------------------------------------------
module pwbs_checker import pwbs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [M_TDATA_W-1:0]  m_axis_tdata,
	input logic                  m_axis_tlast
);

	localparam logic [COLOR_W:0] COLOR_SUM = (COLOR_W + 1)'(ONE_Q + TENTH_Q);

	logic [COLOR_W:0] color_sum;

	assign color_sum = {1'b0, m_axis_tdata[OUT_RED_LSB +: COLOR_W]}
		+ {1'b0, m_axis_tdata[OUT_BLUE_LSB +: COLOR_W]};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// the red and blue ramps are complementary
	a_color_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> color_sum == COLOR_SUM)
		else $error("color ramps do not add up");

	a_heat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[OUT_HEAT_LSB +: HEAT_TOT_W] == '0)
		else $error("heat total shown before end of tick");

	// one item in flight: no second item right behind the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

endmodule

bind particle_wind_bounce_step_top pwbs_checker u_pwbs_checker (.*);

@@ sim/particle_wind_bounce_step_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_wind_bounce_step_top_test
// Self-checking bench: drives particle items through the stream ports and
// checks every result against a cycle-free fixed-point predictor of the
// wind, bounce, heat and color math.
// ----------------------------------------------------------------------------
module particle_wind_bounce_step_top_test;
	import pwbs_pkg::*;

	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [FIELD_W-1:0]    pos_x;
		logic [FIELD_W-1:0]    pos_y;
		logic [FIELD_W-1:0]    vel_x;
		logic [FIELD_W-1:0]    vel_y;
		logic [COLOR_W-1:0]    red;
		logic [COLOR_W-1:0]    blue;
		logic [HEAT_TOT_W-1:0] heat_total;
		logic                  tick_done;
	} particle_out_t;

	typedef enum {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

	// predictor state, register shadows and the queue of expected particles
	class particle_step_model;
		longint bnd_left, bnd_right, bnd_bottom, bnd_top;
		longint acc_x_init, acc_y_init, speed_lim, heat_gain;
		longint wind_vx, wind_vy, wind_ax, wind_ay, heat_sum;
		particle_out_t expected_q[$];
		int n_errors;
		int n_reported;

		function new();
			bnd_left   = RST_BOUND_LO;
			bnd_right  = RST_BOUND_HI;
			bnd_bottom = RST_BOUND_LO;
			bnd_top    = RST_BOUND_HI;
			acc_x_init = RST_ACC_X;
			acc_y_init = RST_ACC_Y;
			speed_lim  = RST_LIMIT;
			heat_gain  = RST_SCALE;
			wind_vx    = 0;
			wind_vy    = 0;
			wind_ax    = acc_x_init;
			wind_ay    = acc_y_init;
			heat_sum   = 0;
			n_errors   = 0;
			n_reported = 0;
		endfunction

		// round to nearest, ties up, dropping the fraction bits
		function longint round_shift(longint v);
			return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		endfunction

		function longint clip24(longint v);
			longint hi;
			hi = (longint'(1) <<< (FIELD_W - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		function longint tick_scale(longint v);
			return round_shift(v * TICK_Q);
		endfunction

		function void advance_wind(inout longint vel, inout longint acc);
			if (vel < -speed_lim || vel > speed_lim) begin
				vel = (vel < -speed_lim) ? -speed_lim : speed_lim;
				acc = clip24(-acc);
			end
			vel = clip24(vel + tick_scale(acc));
		endfunction

		function void move_axis(longint pos, longint vel, longint wind, longint lo,
				longint hi, output longint npos, output longint nvel);
			nvel = clip24(vel + tick_scale(wind));
			npos = pos + tick_scale(nvel);
			if (npos < lo) begin
				npos = lo;
				nvel = clip24(-nvel);
			end else if (npos > hi) begin
				npos = hi;
				nvel = clip24(-nvel);
			end
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_BOUND_LEFT:   bnd_left = longint'($signed(val));
				REG_BOUND_RIGHT:  bnd_right = longint'($signed(val));
				REG_BOUND_BOTTOM: bnd_bottom = longint'($signed(val));
				REG_BOUND_TOP:    bnd_top = longint'($signed(val));
				REG_ACC_X_START: begin
					acc_x_init = longint'($signed(val));
					wind_ax = acc_x_init;
				end
				REG_ACC_Y_START: begin
					acc_y_init = longint'($signed(val));
					wind_ay = acc_y_init;
				end
				REG_SPEED_LIMIT:  speed_lim = longint'(val[LIM_W-1:0]);
				REG_HEAT_SCALE:   heat_gain = longint'(val[LIM_W-1:0]);
				default: ;
			endcase
		endfunction

		function void note_particle(logic [S_TDATA_W-1:0] d, logic first, logic last);
			longint px, py, vx, vy, sq, heat, ramp, nx, ny, nvx, nvy;
			particle_out_t e;
			px = longint'($signed(d[FIELD_W-1:0]));
			py = longint'($signed(d[2*FIELD_W-1:FIELD_W]));
			vx = longint'($signed(d[3*FIELD_W-1:2*FIELD_W]));
			vy = longint'($signed(d[4*FIELD_W-1:3*FIELD_W]));
			if (first) begin
				advance_wind(wind_vx, wind_ax);
				advance_wind(wind_vy, wind_ay);
				heat_sum = 0;
			end
			// heat comes from the incoming velocity
			sq = round_shift(vx * vx + vy * vy);
			heat = round_shift(sq * heat_gain);
			if (heat > ONE_Q)
				heat = ONE_Q;
			move_axis(px, vx, wind_vx, bnd_left, bnd_right, nx, nvx);
			move_axis(py, vy, wind_vy, bnd_bottom, bnd_top, ny, nvy);
			ramp = round_shift(heat * RAMP_K);
			heat_sum += heat;
			if (heat_sum > HEAT_CAP)
				heat_sum = HEAT_CAP;
			e.pos_x = nx[FIELD_W-1:0];
			e.pos_y = ny[FIELD_W-1:0];
			e.vel_x = nvx[FIELD_W-1:0];
			e.vel_y = nvy[FIELD_W-1:0];
			e.red = COLOR_W'(TENTH_Q + ramp);
			e.blue = COLOR_W'(ONE_Q - ramp);
			e.heat_total = last ? HEAT_TOT_W'(heat_sum) : '0;
			e.tick_done = last;
			expected_q.push_back(e);
		endfunction

		function void compare(string name, bit [63:0] exp_v, bit [63:0] act_v);
			if (exp_v != act_v) begin
				n_errors++;
				if (n_reported < 10)
					$display("%0t: %s mismatch: expected %h, got %h", $time, name,
						exp_v, act_v);
				n_reported++;
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] d, logic last);
			particle_out_t e;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_reported < 10)
					$display("%0t: result item with no particle pending: %h", $time, d);
				n_reported++;
				return;
			end
			e = expected_q.pop_front();
			compare("new_pos_x", e.pos_x, d[FIELD_W-1:0]);
			compare("new_pos_y", e.pos_y, d[2*FIELD_W-1:FIELD_W]);
			compare("new_vel_x", e.vel_x, d[3*FIELD_W-1:2*FIELD_W]);
			compare("new_vel_y", e.vel_y, d[4*FIELD_W-1:3*FIELD_W]);
			compare("color_red", e.red, d[OUT_RED_LSB +: COLOR_W]);
			compare("color_blue", e.blue, d[OUT_BLUE_LSB +: COLOR_W]);
			compare("heat_total", e.heat_total, d[OUT_HEAT_LSB +: HEAT_TOT_W]);
			compare("tick_done", e.tick_done, last);
			compare("tdata pad", 0, d[M_TDATA_W-1:OUT_USED_W]);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	particle_step_model predictor = new();
	bit hold_req = 1'b0;

	particle_wind_bounce_step_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predictor.note_particle(s_axis_tdata, s_axis_tuser, s_axis_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			predictor.check_result(m_axis_tdata, m_axis_tlast);
	end

	// result side: random stall patterns, plus a long hold-off on request
	initial begin : result_sink
		sink_mode_t mode;
		int mode_left, hold_left, beat;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		beat = 0;
		forever begin
			@(posedge clk);
			beat++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					SINK_OPEN:   m_axis_tready <= 1'b1;
					SINK_HALF:   m_axis_tready <= $urandom_range(0, 1);
					SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default:     m_axis_tready <= (beat % 7 >= 2);
				endcase
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		predictor.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_particle(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
			logic [FIELD_W-1:0] vx, logic [FIELD_W-1:0] vy, logic first, logic last,
			int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {vy, vx, py, px};
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] make_coord(longint lo, longint hi);
		if (lo <= hi && $urandom_range(0, 1) == 1)
			return FIELD_W'(lo + longint'($urandom_range(0, hi - lo)));
		return FIELD_W'($urandom());
	endfunction

	function automatic logic [FIELD_W-1:0] make_vel(bit slow);
		if (slow)
			return FIELD_W'(longint'($urandom_range(0, 2 ** 21)) - 2 ** 20);
		return FIELD_W'($urandom());
	endfunction

	task automatic random_config(bit crossed);
		longint lo_x, hi_x, lo_y, hi_y, t;
		lo_x = -longint'($urandom_range(0, 2 ** 21));
		hi_x = $urandom_range(0, 2 ** 21);
		lo_y = -longint'($urandom_range(0, 2 ** 21));
		hi_y = $urandom_range(0, 2 ** 21);
		if ($urandom_range(0, 3) == 0) begin
			lo_x = longint'($signed(FIELD_W'($urandom())));
			hi_y = longint'($signed(FIELD_W'($urandom())));
		end
		if (crossed) begin
			t = lo_x; lo_x = hi_x + 1; hi_x = t;
			t = lo_y; lo_y = hi_y; hi_y = t;
		end
		write_reg(REG_BOUND_LEFT, FIELD_W'(lo_x));
		write_reg(REG_BOUND_RIGHT, FIELD_W'(hi_x));
		write_reg(REG_BOUND_BOTTOM, FIELD_W'(lo_y));
		write_reg(REG_BOUND_TOP, FIELD_W'(hi_y));
		write_reg(REG_ACC_X_START, FIELD_W'($urandom()));
		write_reg(REG_ACC_Y_START, FIELD_W'($urandom()));
		write_reg(REG_SPEED_LIMIT, $urandom_range(0, 1) ? FIELD_W'($urandom_range(0, 2 ** 20))
			: FIELD_W'($urandom()));
		write_reg(REG_HEAT_SCALE, $urandom_range(0, 1) ? FIELD_W'($urandom_range(0, 2 ** 19))
			: FIELD_W'($urandom()));
	endtask

	// accumulate: one tick start only, so the heat sum runs into its cap
	task automatic run_phase(int n_items, int max_tick, bit accumulate, bit bursty,
			int hold_at, int drain_at);
		int tick_left, burst_left, gap;
		logic first, last;
		bit slow;
		tick_left = 0;
		burst_left = 0;
		for (int i = 0; i < n_items; i++) begin
			if (accumulate) begin
				first = (i == 0);
				last = ($urandom_range(0, 15) == 0);
				slow = ($urandom_range(0, 9) == 0);
			end else begin
				slow = $urandom_range(0, 1);
				if ($urandom_range(0, 6) == 0) begin
					first = $urandom_range(0, 1);
					last = $urandom_range(0, 1);
				end else begin
					if (tick_left == 0) begin
						tick_left = $urandom_range(1, max_tick);
						first = 1'b1;
					end else begin
						first = 1'b0;
					end
					last = (tick_left == 1);
					tick_left--;
				end
			end
			gap = 0;
			if (bursty) begin
				if (burst_left == 0) begin
					gap = $urandom_range(1, 24);
					burst_left = $urandom_range(1, 30);
				end
				burst_left--;
			end
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == drain_at)
				wait_drained();
			send_particle(make_coord(predictor.bnd_left, predictor.bnd_right),
				make_coord(predictor.bnd_bottom, predictor.bnd_top),
				make_vel(slow), make_vel(slow), first, last, gap);
		end
		wait_drained();
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed items on the reset settings
		send_particle(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0, 0);
		send_particle(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b0, 0);
		send_particle(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, 0);
		send_particle(24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0, 0);
		send_particle(24'h0FF000, 24'hF01000, 24'h200000, 24'hE00000, 1'b0, 1'b0, 0);
		send_particle(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0, 1'b1, 0);
		send_particle(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b1, 1'b1, 0);
		send_particle(24'h080000, 24'hF80000, 24'h0C0000, 24'hF40000, 1'b1, 1'b0, 0);
		send_particle(24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF, 1'b0, 1'b0, 0);
		send_particle(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1, 0);
		send_particle(24'h000000, 24'h000000, 24'h19999A, 24'h000000, 1'b0, 1'b1, 0);
		send_particle(24'h000000, 24'h000000, 24'h100000, 24'h100000, 1'b0, 1'b1, 3);
		send_particle(24'h000000, 24'h100000, 24'h000000, 24'hF00000, 1'b1, 1'b0, 0);
		send_particle(24'hF00000, 24'h000000, 24'hF00000, 24'h000000, 1'b1, 1'b1, 0);
		wait_drained();

		// widest bounds, strongest wind, no heat: drives wind to saturation
		write_reg(REG_BOUND_LEFT, 24'h800000);
		write_reg(REG_BOUND_RIGHT, 24'h7FFFFF);
		write_reg(REG_BOUND_BOTTOM, 24'h800000);
		write_reg(REG_BOUND_TOP, 24'h7FFFFF);
		write_reg(REG_ACC_X_START, 24'h7FFFFF);
		write_reg(REG_ACC_Y_START, 24'h800000);
		write_reg(REG_SPEED_LIMIT, 24'h7FFFFF);
		write_reg(REG_HEAT_SCALE, 24'h000000);
		run_phase(170, 1, 1'b0, 1'b0, -1, -1);

		// zero speed limit: wind clamps and flips every tick
		random_config(1'b0);
		write_reg(REG_ACC_Y_START, 24'h800000);
		write_reg(REG_SPEED_LIMIT, 24'h000000);
		write_reg(REG_HEAT_SCALE, 24'h7FFFFF);
		run_phase(100, 4, 1'b0, 1'b1, -1, -1);

		write_reg(REG_SPEED_LIMIT, FIELD_W'($urandom_range(0, 2 ** 21)));
		run_phase(1150, 1, 1'b1, 1'b1, 300, 700);

		for (int k = 0; k < 4; k++) begin
			random_config(k == 1);
			run_phase(60, 12, 1'b0, k[0], (k == 0) ? 15 : -1, -1);
		end

		repeat (40) @(posedge clk);
		if (predictor.n_errors + predictor.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#15ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
